FILE: rtl/trlmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trlmd_pkg: shared constants and types for the tile run-length map decoder
// Request kinds, register indexes, scan geometry and the reciprocal constants
// used to fold a skipped position back into a column or row.
// ----------------------------------------------------------------------------
package trlmd_pkg;

  // Sheet storage
  localparam int SHEET_DEPTH = 256;
  localparam int SHEET_AW    = (SHEET_DEPTH > 1) ? $clog2(SHEET_DEPTH) : 1;
  localparam int SHEET_W     = 16;
  // 9-bit limit so that an 8-bit code can be compared against a full depth
  localparam logic [8:0] SHEET_LIMIT = 9'(SHEET_DEPTH);

  // Request kinds
  localparam logic [1:0] KIND_SHEET = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Register indexes
  localparam logic CFG_SCAN_MODE  = 1'b0;
  localparam logic CFG_TILE_TOTAL = 1'b1;

  // Tile codes and geometry
  localparam logic [7:0]  SKIP_CODE  = 8'hFF;
  localparam logic [15:0] TILE_STEP  = 16'd16;
  localparam logic [15:0] COL_HEIGHT = 16'd368;
  localparam logic [15:0] ROW_WIDTH  = 16'd640;

  // Line lengths in tiles: 368/16 and 640/16
  localparam logic [5:0] COL_TILES = 6'(368 / 16);
  localparam logic [5:0] ROW_TILES = 6'(640 / 16);

  // floor(a / n) = (a * ceil(2^18 / n)) >> 18, exact for any 13-bit a
  localparam int          RECIP_SHIFT = 18;
  localparam logic [13:0] COL_RECIP   = 14'(((1 << 18) + 23 - 1) / 23);
  localparam logic [13:0] ROW_RECIP   = 14'(((1 << 18) + 40 - 1) / 40);

  // Tile waiting for its sheet lookup
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] tile_number;
    logic        last_tile;
    logic        code_ok;
  } tile_t;

endpackage

FILE: rtl/tile_run_length_map_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_run_length_map_decoder: run-length tile map to placed tiles
// Sheet writes fill a sprite/palette RAM, run requests arm a run, skip
// requests move the cursor, ticks place at most one tile each.
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/stall   | kind, entry, sprite, palette, code, run
//   out     | output    | out_valid/stall  | pos_x, pos_y, sprite, palette, number, last
//   cfg     | input     | cfg_we           | cfg_index, cfg_wdata
//
// Sheet writes, runs and ticks are taken back to back while in_stall is low;
// a tick's tile passes the sheet RAM read, then the output register.
// A skip does the reciprocal multiply, then the fold back into the line;
// in_stall is high during the fold.
// rst_n is synchronous; the sheet RAM is not cleared.
// out_stall holds the output register and one tile behind it, then in_stall.
// ----------------------------------------------------------------------------
module tile_run_length_map_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_sprite_value,
  input  logic [7:0]  in_palette_value,
  input  logic [7:0]  in_code,
  input  logic [7:0]  in_run_length,
  // tile channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [7:0]  out_sprite,
  output logic [7:0]  out_palette,
  output logic [15:0] out_tile_number,
  output logic        out_last_tile
);

  import trlmd_pkg::*;

  // Registers
  logic        scan_mode_r;
  logic [15:0] tile_total_r;
  logic [15:0] cursor_x_r, cursor_x_nxt;
  logic [15:0] cursor_y_r, cursor_y_nxt;
  logic [15:0] tiles_placed_r, tiles_placed_nxt;
  logic [7:0]  pending_code_r, pending_code_nxt;
  logic [7:0]  pending_left_r, pending_left_nxt;

  logic        skip_busy_r;
  logic [12:0] skip_a_r;
  logic [7:0]  skip_q_r;
  logic [3:0]  skip_low_r;

  logic        lkp_valid_r, lkp_valid_nxt;
  tile_t       lkp_r;

  logic        out_valid_r;
  logic [15:0] out_pos_x_r, out_pos_y_r, out_tile_number_r;
  logic [7:0]  out_sprite_r, out_palette_r;
  logic        out_last_tile_r;

  // Handshake
  logic in_acc;
  logic lkp_move;
  logic is_sheet, is_run, is_tick;
  logic tick_emit;

  assign lkp_move = !out_valid_r || !out_stall;
  assign in_stall = skip_busy_r || (lkp_valid_r && !lkp_move);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    is_sheet = 1'b0;
    is_run   = 1'b0;
    is_tick  = 1'b0;
    unique case (in_kind)
      KIND_SHEET: is_sheet = in_acc;
      KIND_RUN:   is_run   = in_acc;
      KIND_TICK:  is_tick  = in_acc;
      default: ;
    endcase
  end

  assign tick_emit = is_tick && (pending_left_r != 8'd0) &&
                     (tiles_placed_r < tile_total_r);

  // Sheet RAM: sprite low byte, palette high byte
  logic                sheet_we;
  logic [SHEET_W-1:0]  sheet_rdata;

  assign sheet_we = is_sheet && ({1'b0, in_entry_index} < SHEET_LIMIT);

  trlmd_ram #(
    .WIDTH (SHEET_W),
    .DEPTH (SHEET_DEPTH)
  ) u_sheet (
    .clk   (clk),
    .we    (sheet_we),
    .waddr (in_entry_index[SHEET_AW-1:0]),
    .wdata ({in_palette_value, in_sprite_value}),
    .re    (tick_emit),
    .raddr (pending_code_r[SHEET_AW-1:0]),
    .rdata (sheet_rdata)
  );

  // Skip, on acceptance: position along the scan axis in tiles, and quotient
  logic        is_skip;
  logic [16:0] along;
  logic [12:0] along_tiles;
  logic [26:0] recip_prod;

  assign is_skip     = is_run && (in_code == SKIP_CODE);
  assign along       = {1'b0, (scan_mode_r ? cursor_x_r : cursor_y_r)} +
                       {5'd0, in_run_length, 4'd0};
  assign along_tiles = along[16:4];
  assign recip_prod  = 27'(along_tiles) * 27'(scan_mode_r ? ROW_RECIP : COL_RECIP);

  // Skip, while skip_busy_r is high: remainder in tiles and carry into the other axis
  logic [13:0] skip_rem;
  logic [15:0] skip_scan;
  logic [15:0] skip_carry;

  assign skip_rem   = {1'b0, skip_a_r} -
                      (14'(skip_q_r) * 14'(scan_mode_r ? ROW_TILES : COL_TILES));
  assign skip_scan  = {6'd0, skip_rem[5:0], skip_low_r};
  assign skip_carry = {4'd0, skip_q_r, 4'd0};

  // Cursor, counters and pending run
  logic [15:0] step_x, step_y;

  assign step_x = cursor_x_r + TILE_STEP;
  assign step_y = cursor_y_r + TILE_STEP;

  always_comb begin
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    tiles_placed_nxt = tiles_placed_r;
    pending_code_nxt = pending_code_r;
    pending_left_nxt = pending_left_r;
    if (skip_busy_r) begin
      if (scan_mode_r) begin
        cursor_x_nxt = skip_scan;
        cursor_y_nxt = cursor_y_r + skip_carry;
      end else begin
        cursor_y_nxt = skip_scan;
        cursor_x_nxt = cursor_x_r + skip_carry;
      end
    end else if (tick_emit) begin
      tiles_placed_nxt = tiles_placed_r + 16'd1;
      pending_left_nxt = pending_left_r - 8'd1;
      if (scan_mode_r) begin
        if (step_x == ROW_WIDTH) begin
          cursor_x_nxt = 16'd0;
          cursor_y_nxt = step_y;
        end else begin
          cursor_x_nxt = step_x;
        end
      end else begin
        if (step_y == COL_HEIGHT) begin
          cursor_y_nxt = 16'd0;
          cursor_x_nxt = step_x;
        end else begin
          cursor_y_nxt = step_y;
        end
      end
    end else if (is_run && !is_skip) begin
      pending_code_nxt = in_code;
      pending_left_nxt = in_run_length;
    end
  end

  // Lookup stage occupancy
  always_comb begin
    lkp_valid_nxt = lkp_valid_r;
    if (tick_emit) begin
      lkp_valid_nxt = 1'b1;
    end else if (lkp_move) begin
      lkp_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_mode_r    <= 1'b0;
      tile_total_r   <= 16'd0;
      cursor_x_r     <= 16'd0;
      cursor_y_r     <= 16'd0;
      tiles_placed_r <= 16'd0;
      pending_code_r <= 8'd0;
      pending_left_r <= 8'd0;
      skip_busy_r    <= 1'b0;
      lkp_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCAN_MODE:  scan_mode_r  <= cfg_wdata[0];
          CFG_TILE_TOTAL: tile_total_r <= cfg_wdata;
          default: ;
        endcase
      end
      cursor_x_r     <= cursor_x_nxt;
      cursor_y_r     <= cursor_y_nxt;
      tiles_placed_r <= tiles_placed_nxt;
      pending_code_r <= pending_code_nxt;
      pending_left_r <= pending_left_nxt;
      skip_busy_r    <= is_skip;
      lkp_valid_r    <= lkp_valid_nxt;
      if (lkp_valid_r && lkp_move) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (is_skip) begin
      skip_a_r   <= along_tiles;
      skip_q_r   <= recip_prod[RECIP_SHIFT +: 8];
      skip_low_r <= along[3:0];
    end
    if (tick_emit) begin
      lkp_r.pos_x       <= cursor_x_r;
      lkp_r.pos_y       <= cursor_y_r;
      lkp_r.tile_number <= tiles_placed_r;
      lkp_r.last_tile   <= ((tiles_placed_r + 16'd1) == tile_total_r);
      lkp_r.code_ok     <= ({1'b0, pending_code_r} < SHEET_LIMIT);
    end
    if (lkp_valid_r && lkp_move) begin
      out_pos_x_r       <= lkp_r.pos_x;
      out_pos_y_r       <= lkp_r.pos_y;
      out_tile_number_r <= lkp_r.tile_number;
      out_last_tile_r   <= lkp_r.last_tile;
      out_sprite_r      <= lkp_r.code_ok ? sheet_rdata[7:0]  : 8'd0;
      out_palette_r     <= lkp_r.code_ok ? sheet_rdata[15:8] : 8'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = out_pos_x_r;
  assign out_pos_y       = out_pos_y_r;
  assign out_sprite      = out_sprite_r;
  assign out_palette     = out_palette_r;
  assign out_tile_number = out_tile_number_r;
  assign out_last_tile   = out_last_tile_r;

endmodule

FILE: rtl/trlmd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trlmd_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered, held when idle.
// ----------------------------------------------------------------------------
module trlmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
